// ===== rtl/core/rbsd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsd_pkg: shared types and constants of the rx buffer snap deframer
// Request/response payloads, front-to-back command entry and frame constants.
// ----------------------------------------------------------------------------
package rbsd_pkg;

   localparam int MAX_FRAME_BYTES = 1600;
   localparam int BUFFER_BYTES    = 4096;

   localparam int HDR_BYTES      = 4;
   localparam int DESC_BYTES     = 20;
   localparam int HEAD_BYTES     = 22;
   localparam int EARLY_BYTES    = 10;
   localparam int MAC_BYTES      = 12;
   localparam int SNAP_POS       = 14;
   localparam int SNAP_LEN       = 6;
   localparam int ETYPE_POS      = 20;
   localparam int ETH_HEAD_ITEMS = 14;

   localparam logic [15:0] EAPOL_TYPE = 16'h888E;
   localparam logic [SNAP_LEN-1:0][7:0] SNAP_HDR =
      {8'h00, 8'h00, 8'h00, 8'h03, 8'hAA, 8'hAA};

   localparam int CNT_W   = $clog2(BUFFER_BYTES + 1);
   localparam int LEN_W   = $clog2(MAX_FRAME_BYTES + 1);
   localparam int POS_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int EIDX_W  = $clog2(EARLY_BYTES - 1);
   localparam int EV_W    = $clog2(EARLY_BYTES);
   localparam int HIDX_W  = $clog2(HEAD_BYTES - 1);
   localparam int BURST_W = $clog2(ETH_HEAD_ITEMS + 1);

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_ETH     = 2'd0,
      KIND_EAPOL   = 2'd1,
      KIND_VERDICT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      VERD_DATA  = 3'd0,
      VERD_EAPOL = 3'd1,
      VERD_BAD   = 3'd2,
      VERD_SHORT = 3'd3,
      VERD_TRUNC = 3'd4
   } verdict_type;

   typedef enum logic [7:0] {
      PH_HEADER     = 8'b0000_0001,
      PH_HEAD       = 8'b0000_0010,
      PH_ETH        = 8'b0000_0100,
      PH_EAPOL      = 8'b0000_1000,
      PH_DONE_DATA  = 8'b0001_0000,
      PH_DONE_EAPOL = 8'b0010_0000,
      PH_DONE_BAD   = 8'b0100_0000,
      PH_DONE_SHORT = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      kind_type    item_kind;
      verdict_type verdict;
   } rsp_type;

   typedef struct packed {
      logic        has_head;
      logic        has_byte;
      logic [7:0]  byte_val;
      kind_type    byte_kind;
      logic        has_verdict;
      verdict_type verdict;
   } cmd_type;

   typedef logic [ETH_HEAD_ITEMS-1:0][7:0] head_bytes_type;

endpackage

// ===== rtl/core/rbsd_front.sv =====
// ----------------------------------------------------------------------------
// rbsd_front: buffer parser
// Takes one buffer byte per cycle unless the queue or head hold stalls, checks
// header bounds and snap header; each byte gives at most one command entry.
// ----------------------------------------------------------------------------
module rbsd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rbsd_pkg::req_type       req_data,
   input  logic                    q_full,
   output logic                    push,
   output rbsd_pkg::cmd_type       push_cmd,
   output rbsd_pkg::head_bytes_type hold_bytes,
   input  logic                    hold_take
);

   rbsd_pkg::phase_type phase_ff, phase_in, phase_mid;
   logic [rbsd_pkg::CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [rbsd_pkg::CNT_W-1:0] start_ff, start_in;
   logic [rbsd_pkg::LEN_W-1:0] packet_length_ff, packet_length_in;
   logic [7:0] early_ff [rbsd_pkg::EARLY_BYTES-1];
   logic [7:0] early_in [rbsd_pkg::EARLY_BYTES-1];
   logic [7:0] frame_head_ff [rbsd_pkg::HEAD_BYTES-1];
   logic [7:0] frame_head_in [rbsd_pkg::HEAD_BYTES-1];
   logic [7:0] ev [rbsd_pkg::EARLY_BYTES];
   rbsd_pkg::head_bytes_type hold_ff, hold_in;
   logic hold_busy_ff, hold_busy_in;

   logic [7:0] b;
   logic accept, p_ok, in_frame, head_hit, head_end, strm_hit, strm_end, snap_ok;
   logic [rbsd_pkg::CNT_W-1:0] fp;
   logic [15:0] blen, plen_w, off_w, etype;
   logic [17:0] span, span_hdr;
   logic hdr_bad, hdr_short, len_is_head;

   assign b         = req_data.data_byte;
   assign p_ok      = byte_count_ff < rbsd_pkg::CNT_W'(rbsd_pkg::BUFFER_BYTES);
   assign in_frame  = byte_count_ff >= start_ff;
   assign fp        = byte_count_ff - start_ff;
   assign head_hit  = (phase_ff == rbsd_pkg::PH_HEAD) && p_ok && in_frame &&
                      (fp < rbsd_pkg::CNT_W'(rbsd_pkg::HEAD_BYTES));
   assign head_end  = head_hit && (fp == rbsd_pkg::CNT_W'(rbsd_pkg::HEAD_BYTES - 1));
   assign strm_hit  = ((phase_ff == rbsd_pkg::PH_ETH) || (phase_ff == rbsd_pkg::PH_EAPOL)) &&
                      p_ok && in_frame &&
                      (rbsd_pkg::POS_W'(fp) < rbsd_pkg::POS_W'(packet_length_ff));
   assign strm_end  = rbsd_pkg::POS_W'(fp) ==
                      (rbsd_pkg::POS_W'(packet_length_ff) - rbsd_pkg::POS_W'(1));
   assign len_is_head = packet_length_ff == rbsd_pkg::LEN_W'(rbsd_pkg::HEAD_BYTES);

   assign req_ready = !q_full && !(head_end && hold_busy_ff);
   assign accept    = req_valid && req_ready;
   assign hold_bytes = hold_ff;

   // header fields, the offset high byte is the byte arriving now
   assign blen     = {early_ff[1], early_ff[0]};
   assign plen_w   = {early_ff[7], early_ff[6]};
   assign off_w    = {b, early_ff[8]};
   assign span     = 18'(off_w) + 18'(plen_w);
   assign span_hdr = span + 18'(rbsd_pkg::HDR_BYTES);
   assign hdr_bad  = (blen < 16'(rbsd_pkg::HDR_BYTES + rbsd_pkg::DESC_BYTES)) ||
                     (plen_w == 16'd0) ||
                     (plen_w > 16'(rbsd_pkg::MAX_FRAME_BYTES)) ||
                     (span > (18'(blen) - 18'(rbsd_pkg::HDR_BYTES))) ||
                     (span_hdr > 18'(rbsd_pkg::BUFFER_BYTES));
   assign hdr_short = plen_w < 16'(rbsd_pkg::HEAD_BYTES);

   assign etype = {frame_head_ff[rbsd_pkg::ETYPE_POS], b};

   always_comb begin
      snap_ok = 1'b1;
      for (int k = 0; k < rbsd_pkg::SNAP_LEN; k++) begin
         if (frame_head_ff[rbsd_pkg::SNAP_POS + k] != rbsd_pkg::SNAP_HDR[k]) begin
            snap_ok = 1'b0;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < rbsd_pkg::EARLY_BYTES - 1; k++) begin
         ev[k] = early_ff[k];
      end
      ev[rbsd_pkg::EARLY_BYTES-1] = b;
   end

   always_comb begin
      phase_in         = phase_ff;
      phase_mid        = phase_ff;
      byte_count_in    = byte_count_ff;
      start_in         = start_ff;
      packet_length_in = packet_length_ff;
      early_in         = early_ff;
      frame_head_in    = frame_head_ff;
      hold_in          = hold_ff;
      hold_busy_in     = hold_busy_ff;
      push_cmd         = '0;
      if (hold_take) begin
         hold_busy_in = 1'b0;
      end
      if (accept) begin
         case (phase_ff)
            rbsd_pkg::PH_HEADER: begin
               if (p_ok && (byte_count_ff < rbsd_pkg::CNT_W'(rbsd_pkg::EARLY_BYTES - 1))) begin
                  early_in[byte_count_ff[rbsd_pkg::EIDX_W-1:0]] = b;
               end
               if (p_ok && (byte_count_ff == rbsd_pkg::CNT_W'(rbsd_pkg::EARLY_BYTES - 1))) begin
                  if (hdr_bad) begin
                     phase_mid = rbsd_pkg::PH_DONE_BAD;
                  end else if (hdr_short) begin
                     phase_mid = rbsd_pkg::PH_DONE_SHORT;
                  end else begin
                     phase_mid        = rbsd_pkg::PH_HEAD;
                     packet_length_in = plen_w[rbsd_pkg::LEN_W-1:0];
                     start_in         = rbsd_pkg::CNT_W'(span_hdr - 18'(plen_w));
                     // frame starting inside the captured bytes
                     for (int j = 0; j < rbsd_pkg::EARLY_BYTES - rbsd_pkg::HDR_BYTES; j++) begin
                        if ((17'(off_w) + 17'(j)) <=
                            17'(rbsd_pkg::EARLY_BYTES - 1 - rbsd_pkg::HDR_BYTES)) begin
                           frame_head_in[j] = ev[rbsd_pkg::EV_W'(rbsd_pkg::HDR_BYTES + j) +
                                                 off_w[rbsd_pkg::EV_W-1:0]];
                        end
                     end
                  end
               end
            end
            rbsd_pkg::PH_HEAD: begin
               if (head_hit && !head_end) begin
                  frame_head_in[fp[rbsd_pkg::HIDX_W-1:0]] = b;
               end
               if (head_end) begin
                  if (!snap_ok) begin
                     phase_mid = rbsd_pkg::PH_DONE_SHORT;
                  end else if (etype == rbsd_pkg::EAPOL_TYPE) begin
                     phase_mid = len_is_head ? rbsd_pkg::PH_DONE_EAPOL : rbsd_pkg::PH_EAPOL;
                  end else begin
                     phase_mid = len_is_head ? rbsd_pkg::PH_DONE_DATA : rbsd_pkg::PH_ETH;
                     push_cmd.has_head = 1'b1;
                     hold_busy_in      = 1'b1;
                     for (int k = 0; k < rbsd_pkg::MAC_BYTES; k++) begin
                        hold_in[k] = frame_head_ff[k];
                     end
                     hold_in[rbsd_pkg::MAC_BYTES]     = frame_head_ff[rbsd_pkg::ETYPE_POS];
                     hold_in[rbsd_pkg::MAC_BYTES + 1] = b;
                  end
               end
            end
            rbsd_pkg::PH_ETH, rbsd_pkg::PH_EAPOL: begin
               if (strm_hit) begin
                  push_cmd.has_byte  = 1'b1;
                  push_cmd.byte_val  = b;
                  push_cmd.byte_kind = (phase_ff == rbsd_pkg::PH_EAPOL) ?
                                       rbsd_pkg::KIND_EAPOL : rbsd_pkg::KIND_ETH;
                  if (strm_end) begin
                     phase_mid = (phase_ff == rbsd_pkg::PH_EAPOL) ?
                                 rbsd_pkg::PH_DONE_EAPOL : rbsd_pkg::PH_DONE_DATA;
                  end
               end
            end
            default: begin
            end
         endcase
         if (req_data.last_byte) begin
            push_cmd.has_verdict = 1'b1;
            case (phase_mid)
               rbsd_pkg::PH_DONE_DATA:  push_cmd.verdict = rbsd_pkg::VERD_DATA;
               rbsd_pkg::PH_DONE_EAPOL: push_cmd.verdict = rbsd_pkg::VERD_EAPOL;
               rbsd_pkg::PH_DONE_BAD:   push_cmd.verdict = rbsd_pkg::VERD_BAD;
               rbsd_pkg::PH_DONE_SHORT: push_cmd.verdict = rbsd_pkg::VERD_SHORT;
               default:                 push_cmd.verdict = rbsd_pkg::VERD_TRUNC;
            endcase
            phase_in      = rbsd_pkg::PH_HEADER;
            byte_count_in = '0;
         end else begin
            phase_in = phase_mid;
            if (p_ok) begin
               byte_count_in = byte_count_ff + rbsd_pkg::CNT_W'(1);
            end
         end
      end
   end

   assign push = accept && (push_cmd.has_head || push_cmd.has_byte || push_cmd.has_verdict);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= rbsd_pkg::PH_HEADER;
         byte_count_ff    <= '0;
         start_ff         <= '0;
         packet_length_ff <= '0;
         hold_busy_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         byte_count_ff    <= byte_count_in;
         start_ff         <= start_in;
         packet_length_ff <= packet_length_in;
         hold_busy_ff     <= hold_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      early_ff      <= early_in;
      frame_head_ff <= frame_head_in;
      hold_ff       <= hold_in;
   end

endmodule

// ===== rtl/core/rbsd_queue.sv =====
// ----------------------------------------------------------------------------
// rbsd_queue: command queue
// Short fifo of command entries between the parser and the emitter.
// ----------------------------------------------------------------------------
module rbsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rbsd_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output rbsd_pkg::cmd_type pop_cmd
);

   rbsd_pkg::cmd_type entries_ff [rbsd_pkg::Q_DEPTH];
   logic [rbsd_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rbsd_pkg::Q_CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == rbsd_pkg::Q_CNT_W'(rbsd_pkg::Q_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + rbsd_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + rbsd_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + rbsd_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rbsd_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> (!push || pop))
      else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + rbsd_pkg::Q_CNT_W'(1)))
      else $error("queue count did not follow a write");
`endif

endmodule

// ===== rtl/core/rbsd_back.sv =====
// ----------------------------------------------------------------------------
// rbsd_back: response emitter
// Pops command entries and plays them out as response items: the ethernet
// head burst, a frame or eapol byte, and the end verdict.
// ----------------------------------------------------------------------------
module rbsd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  rbsd_pkg::cmd_type        q_cmd,
   output logic                     pop,
   input  rbsd_pkg::head_bytes_type hold_bytes,
   output logic                     hold_take,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rbsd_pkg::rsp_type        rsp_data
);

   logic cur_valid_ff, cur_valid_in;
   logic [rbsd_pkg::BURST_W-1:0] head_left_ff, head_left_in;
   logic byte_pend_ff, byte_pend_in;
   logic [7:0] byte_ff, byte_in;
   rbsd_pkg::kind_type kind_ff, kind_in;
   logic verd_pend_ff, verd_pend_in;
   rbsd_pkg::verdict_type verd_ff, verd_in;
   rbsd_pkg::head_bytes_type burst_ff, burst_in;

   logic [rbsd_pkg::BURST_W:0] items;
   logic out_accept, load;

   assign items = {1'b0, head_left_ff} + (rbsd_pkg::BURST_W + 1)'(byte_pend_ff) +
                  (rbsd_pkg::BURST_W + 1)'(verd_pend_ff);
   assign rsp_valid  = cur_valid_ff;
   assign out_accept = rsp_valid && rsp_ready;
   assign load       = !cur_valid_ff || (out_accept && (items == (rbsd_pkg::BURST_W + 1)'(1)));
   assign pop        = load && q_valid;
   assign hold_take  = pop && q_cmd.has_head;

   always_comb begin
      rsp_data = '0;
      if (head_left_ff != '0) begin
         rsp_data.out_byte  = burst_ff[0];
         rsp_data.item_kind = rbsd_pkg::KIND_ETH;
      end else if (byte_pend_ff) begin
         rsp_data.out_byte  = byte_ff;
         rsp_data.item_kind = kind_ff;
      end else begin
         rsp_data.item_kind = rbsd_pkg::KIND_VERDICT;
         rsp_data.verdict   = verd_ff;
      end
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      head_left_in = head_left_ff;
      byte_pend_in = byte_pend_ff;
      byte_in      = byte_ff;
      kind_in      = kind_ff;
      verd_pend_in = verd_pend_ff;
      verd_in      = verd_ff;
      burst_in     = burst_ff;
      if (load) begin
         cur_valid_in = q_valid;
         head_left_in = q_cmd.has_head ? rbsd_pkg::BURST_W'(rbsd_pkg::ETH_HEAD_ITEMS) : '0;
         byte_pend_in = q_valid && q_cmd.has_byte;
         byte_in      = q_cmd.byte_val;
         kind_in      = q_cmd.byte_kind;
         verd_pend_in = q_valid && q_cmd.has_verdict;
         verd_in      = q_cmd.verdict;
         if (!q_valid) begin
            head_left_in = '0;
         end
         if (hold_take) begin
            burst_in = hold_bytes;
         end
      end else if (out_accept) begin
         if (head_left_ff != '0) begin
            head_left_in = head_left_ff - rbsd_pkg::BURST_W'(1);
            burst_in     = {8'h00, burst_ff[rbsd_pkg::ETH_HEAD_ITEMS-1:1]};
         end else if (byte_pend_ff) begin
            byte_pend_in = 1'b0;
         end else begin
            verd_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         head_left_ff <= '0;
         byte_pend_ff <= 1'b0;
         verd_pend_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         head_left_ff <= head_left_in;
         byte_pend_ff <= byte_pend_in;
         verd_pend_ff <= verd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      kind_ff  <= kind_in;
      verd_ff  <= verd_in;
      burst_ff <= burst_in;
   end

`ifndef SYNTHESIS
   a_busy_has_items: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (items != '0))
      else $error("emitter holds an entry with nothing left to send");
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      head_left_ff <= rbsd_pkg::BURST_W'(rbsd_pkg::ETH_HEAD_ITEMS))
      else $error("head burst count out of range");
   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (out_accept && (items == (rbsd_pkg::BURST_W + 1)'(1)) && !q_valid) |=> !cur_valid_ff)
      else $error("emitter stayed busy after its last item");
`endif

endmodule

// ===== rtl/core/rx_buffer_snap_deframer.sv =====
// ----------------------------------------------------------------------------
// rx_buffer_snap_deframer: llc/snap to ethernet ii receive deframer
// Parses a receive dma buffer byte by byte and emits the ethernet ii frame
// or the eapol payload, followed by one verdict per buffer.
// ----------------------------------------------------------------------------
// usage
//   req channel: one buffer byte per request, last_byte set on the final byte
//   rsp channel: frame bytes (kind 0), eapol bytes (kind 1), then one verdict
//   item (kind 2) per buffer; a byte that causes a result is registered in the
//   command queue and then in the emitter before it shows up on rsp
//   throughput: one request per cycle; the parser never iterates. when the
//   frame head of a non-eapol frame completes, the 14-item ethernet head goes
//   out from the emitter while the 4-entry command queue keeps taking payload
//   bytes; once it is full, req_ready drops until the emitter catches up
//   req_ready also drops if a second head burst comes before the emitter has
//   picked up the first
//   rsp stall: the emitter holds its item and the queue fills, then req_ready
//   falls; nothing is dropped
//   reset: synchronous; clears the parse phase, byte count, queue and emitter.
//   the header and frame-head byte stores are not cleared
// ----------------------------------------------------------------------------
module rx_buffer_snap_deframer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rbsd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rbsd_pkg::rsp_type rsp_data
);

   logic q_full, push, pop, q_valid, hold_take;
   rbsd_pkg::cmd_type push_cmd, q_cmd;
   rbsd_pkg::head_bytes_type hold_bytes;

   rbsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd),
      .hold_bytes (hold_bytes),
      .hold_take  (hold_take)
   );

   rbsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd)
   );

   rbsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .pop        (pop),
      .hold_bytes (hold_bytes),
      .hold_take  (hold_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== verif/rbsd_checker.sv =====
// ----------------------------------------------------------------------------
// rbsd_checker: response checker for the rx buffer snap deframer
// Watches both channels and predicts the frame, eapol and verdict items of
// every request. Each response is compared field by field with the oldest
// prediction, and the mismatch count goes to the testbench top.
// ----------------------------------------------------------------------------
module rbsd_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  rbsd_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rbsd_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import rbsd_pkg::*;

   int         byte_pos;
   int         buf_len;
   int         pkt_len;
   int         pkt_off;
   logic [7:0] early_mem [EARLY_BYTES];
   logic [7:0] head_mem [HEAD_BYTES];
   phase_type  phase;
   rsp_type    deframed_q [$];
   rsp_type    want;
   int         mismatches = 0;

   task automatic report(input string msg);
      if (mismatches < 20) begin
         $display("%0t: mismatch: %s", $time, msg);
      end
      mismatches++;
   endtask

   task automatic expect_item(input logic [7:0] b, input kind_type k, input verdict_type v);
      rsp_type item;
      item.out_byte  = b;
      item.item_kind = k;
      item.verdict   = v;
      deframed_q.push_back(item);
   endtask

   task automatic deframe_byte(input logic [7:0] d, input logic last);
      int          p;
      int          start;
      int          i;
      logic        snap_ok;
      logic [15:0] etype;
      kind_type    k;
      verdict_type v;
      p     = byte_pos;
      start = HDR_BYTES + pkt_off;
      if (p < BUFFER_BYTES) begin
         case (phase)
            PH_HEADER: begin
               if (p < EARLY_BYTES) begin
                  early_mem[p] = d;
                  if (p == EARLY_BYTES - 1) begin
                     buf_len = {early_mem[1], early_mem[0]};
                     pkt_len = {early_mem[7], early_mem[6]};
                     pkt_off = {early_mem[9], early_mem[8]};
                     start   = HDR_BYTES + pkt_off;
                     if (buf_len < HDR_BYTES + DESC_BYTES || pkt_len == 0 ||
                         pkt_len > MAX_FRAME_BYTES ||
                         pkt_off + pkt_len > buf_len - HDR_BYTES ||
                         HDR_BYTES + pkt_off + pkt_len > BUFFER_BYTES) begin
                        phase = PH_DONE_BAD;
                     end else if (pkt_len < HEAD_BYTES) begin
                        phase = PH_DONE_SHORT;
                     end else begin
                        // frame starting inside the first captured bytes
                        for (i = start; i < EARLY_BYTES; i++) begin
                           head_mem[i - start] = early_mem[i];
                        end
                        phase = PH_HEAD;
                     end
                  end
               end
            end
            PH_HEAD: begin
               if (p >= start && p - start < HEAD_BYTES) begin
                  head_mem[p - start] = d;
                  if (p - start == HEAD_BYTES - 1) begin
                     snap_ok = 1'b1;
                     for (i = 0; i < SNAP_LEN; i++) begin
                        if (head_mem[SNAP_POS + i] != SNAP_HDR[i]) snap_ok = 1'b0;
                     end
                     etype = {head_mem[ETYPE_POS], head_mem[ETYPE_POS + 1]};
                     if (!snap_ok) begin
                        phase = PH_DONE_SHORT;
                     end else if (etype == EAPOL_TYPE) begin
                        phase = (pkt_len == HEAD_BYTES) ? PH_DONE_EAPOL : PH_EAPOL;
                     end else begin
                        for (i = 0; i < MAC_BYTES; i++) begin
                           expect_item(head_mem[i], KIND_ETH, VERD_DATA);
                        end
                        expect_item(etype[15:8], KIND_ETH, VERD_DATA);
                        expect_item(etype[7:0], KIND_ETH, VERD_DATA);
                        phase = (pkt_len == HEAD_BYTES) ? PH_DONE_DATA : PH_ETH;
                     end
                  end
               end
            end
            PH_ETH, PH_EAPOL: begin
               if (p >= start && p - start < pkt_len) begin
                  k = (phase == PH_EAPOL) ? KIND_EAPOL : KIND_ETH;
                  expect_item(d, k, VERD_DATA);
                  if (p - start == pkt_len - 1) begin
                     phase = (phase == PH_EAPOL) ? PH_DONE_EAPOL : PH_DONE_DATA;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (last) begin
         case (phase)
            PH_DONE_DATA:  v = VERD_DATA;
            PH_DONE_EAPOL: v = VERD_EAPOL;
            PH_DONE_BAD:   v = VERD_BAD;
            PH_DONE_SHORT: v = VERD_SHORT;
            default:       v = VERD_TRUNC;
         endcase
         expect_item(8'h00, KIND_VERDICT, v);
         phase    = PH_HEADER;
         byte_pos = 0;
      end else if (byte_pos < BUFFER_BYTES) begin
         byte_pos++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         byte_pos = 0;
         buf_len  = 0;
         pkt_len  = 0;
         pkt_off  = 0;
         phase    = PH_HEADER;
         deframed_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (deframed_q.size() == 0) begin
               report($sformatf("unexpected response byte %02h kind %0d verdict %0d",
                                rsp_data.out_byte, rsp_data.item_kind, rsp_data.verdict));
            end else begin
               want = deframed_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  report($sformatf("out_byte %02h, expected %02h",
                                   rsp_data.out_byte, want.out_byte));
               end
               if (rsp_data.item_kind !== want.item_kind) begin
                  report($sformatf("item_kind %0d, expected %0d",
                                   rsp_data.item_kind, want.item_kind));
               end
               if (rsp_data.verdict !== want.verdict) begin
                  report($sformatf("verdict %0d, expected %0d",
                                   rsp_data.verdict, want.verdict));
               end
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_data.data_byte, req_data.last_byte);
         end
      end
      pending    <= deframed_q.size();
      fail_count <= mismatches;
   end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the rx buffer snap deframer
// Streams directed and random receive buffers into the block, one byte per
// request, with random gaps and response stalls, and gives the verdict from
// the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
   import rbsd_pkg::*;

   localparam int LIMIT_CYCLES  = 1000000;
   localparam int RANDOM_BYTES  = 100;
   localparam int SETTLE_CYCLES = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   bit      quiet     = 1'b0;
   int      rsp_hold  = 0;
   int      bytes_sent = 0;
   int      fail_count;
   int      pending;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rx_buffer_snap_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rbsd_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // response stalls
   always @(posedge clock) begin
      int g;
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= rsp_hold - 1;
      end else begin
         g = pick_gap();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= g - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic last);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: d, last_byte: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // buffer: length field, descriptor with packet length and offset, frame
   // with llc/snap and ethertype at 4 + offset, random fill elsewhere
   task automatic send_buffer(input int blen, input int plen, input int off,
                              input logic [15:0] etype, input bit snap_ok,
                              input int nbytes);
      logic [7:0] stream [$];
      int         fs;
      int         i;
      int         bad_idx;
      stream.delete();
      for (i = 0; i < nbytes; i++) stream.push_back(8'($urandom_range(0, 255)));
      fs      = HDR_BYTES + off;
      bad_idx = $urandom_range(0, SNAP_LEN - 1);
      for (i = 0; i < SNAP_LEN; i++) begin
         if (fs + SNAP_POS + i < nbytes) begin
            stream[fs + SNAP_POS + i] = SNAP_HDR[i];
            if (!snap_ok && i == bad_idx) begin
               stream[fs + SNAP_POS + i] = SNAP_HDR[i] ^ 8'($urandom_range(1, 255));
            end
         end
      end
      if (fs + ETYPE_POS < nbytes) stream[fs + ETYPE_POS] = etype[15:8];
      if (fs + ETYPE_POS + 1 < nbytes) stream[fs + ETYPE_POS + 1] = etype[7:0];
      if (nbytes > 0) stream[0] = blen[7:0];
      if (nbytes > 1) stream[1] = blen[15:8];
      if (nbytes > 6) stream[6] = plen[7:0];
      if (nbytes > 7) stream[7] = plen[15:8];
      if (nbytes > 8) stream[8] = off[7:0];
      if (nbytes > 9) stream[9] = off[15:8];
      for (i = 0; i < nbytes; i++) send_byte(stream[i], i == nbytes - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int r;
      int blen;
      int plen;
      int off;
      int full;
      int nbytes;
      int buffers;
      logic [15:0] etype;
      bit snap_ok;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_buffer(46, 30, 8, 16'h0800, 1'b1, 46);
      send_buffer(26, 22, 0, 16'h86DD, 1'b1, 26);
      send_buffer(26, 22, 0, EAPOL_TYPE, 1'b1, 26);
      send_buffer(33, 23, 5, EAPOL_TYPE, 1'b1, 32);
      send_buffer(23, 22, 0, 16'h0800, 1'b1, 12);
      send_buffer(100, 0, 20, 16'h0800, 1'b1, 12);
      send_buffer(16'hFFFF, MAX_FRAME_BYTES + 1, 20, 16'h0800, 1'b1, 12);
      send_buffer(53, 30, 20, 16'h0800, 1'b1, 12);
      send_buffer(16'hFFFF, MAX_FRAME_BYTES, 2493, 16'h0800, 1'b1, 12);
      // largest frame that still fits the buffer store, cut short
      send_buffer(16'hFFFF, MAX_FRAME_BYTES, 2492, 16'h0800, 1'b1, 12);
      send_buffer(30, 21, 0, 16'h0800, 1'b1, 12);
      send_buffer(28, 24, 0, 16'h0800, 1'b1, 1);
      send_buffer(28, 24, 0, 16'h0800, 1'b1, 6);
      send_buffer(28, 24, 0, 16'h0800, 1'b1, 10);
      drain();

      bytes_sent = 0;
      buffers    = 0;
      while (bytes_sent < RANDOM_BYTES) begin
         quiet   <= ($urandom_range(0, 4) == 0);
         r       = $urandom_range(0, 99);
         snap_ok = ($urandom_range(0, 9) != 0);
         etype   = $urandom_range(0, 1) ? EAPOL_TYPE : 16'($urandom_range(0, 65535));
         if (r < 70) begin
            off  = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 6) : $urandom_range(7, 40);
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(61, 120)
                                                : $urandom_range(HEAD_BYTES, 60);
            full = HDR_BYTES + off + plen;
            blen = full + $urandom_range(0, 6);
            nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(1, full - 1)
                                                 : full + $urandom_range(0, 3);
         end else if (r < 85) begin
            blen   = $urandom_range(0, 65535);
            plen   = $urandom_range(0, 65535);
            off    = $urandom_range(0, 65535);
            nbytes = $urandom_range(EARLY_BYTES, 16);
         end else begin
            off    = $urandom_range(0, 40);
            plen   = $urandom_range(1, HEAD_BYTES - 1);
            full   = HDR_BYTES + off + plen;
            blen   = full + $urandom_range(0, 6);
            if (blen < HDR_BYTES + DESC_BYTES) blen = HDR_BYTES + DESC_BYTES;
            nbytes = full + $urandom_range(0, 3);
         end
         send_buffer(blen, plen, off, etype, snap_ok, nbytes);
         buffers++;
         if (buffers % 8 == 0) drain();
      end
      quiet <= 1'b0;
      drain();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/rbsd_pkg.sv
rtl/core/rbsd_front.sv
rtl/core/rbsd_queue.sv
rtl/core/rbsd_back.sv
rtl/core/rx_buffer_snap_deframer.sv
verif/rbsd_checker.sv
verif/testbench.sv
